[design/mch_pkg.sv]
// ----------------------------------------------------------------------------
// mch_pkg: shared types and constants of the calibrated heading block
// Holds the sequencer states and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package mch_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CALC,
    ST_MUL,
    ST_CORDIC,
    ST_OUT
  } state_t;

  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned DIFF_W   = 18;
  localparam int unsigned RANGE_W  = 17;
  localparam int unsigned PROD_W   = DIFF_W + RANGE_W;
  localparam int unsigned CORD_W   = 64;
  localparam int unsigned ACC_W    = 32;
  localparam int unsigned PRESCALE = 24;
  localparam int unsigned MAX_STEPS = 24;

  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7FFF;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;
  localparam logic [ACC_W-1:0] HALF_TURN = 32'h8000_0000;

  function automatic logic [ACC_W-1:0] atan_turn(input logic [4:0] idx);
    logic [ACC_W-1:0] v;
    begin
      case (idx)
        5'd0:  v = 32'd536870912;
        5'd1:  v = 32'd316933406;
        5'd2:  v = 32'd167458907;
        5'd3:  v = 32'd85004756;
        5'd4:  v = 32'd42667331;
        5'd5:  v = 32'd21354465;
        5'd6:  v = 32'd10680862;
        5'd7:  v = 32'd5340245;
        5'd8:  v = 32'd2670163;
        5'd9:  v = 32'd1335087;
        5'd10: v = 32'd667544;
        5'd11: v = 32'd333772;
        5'd12: v = 32'd166886;
        5'd13: v = 32'd83443;
        5'd14: v = 32'd41722;
        5'd15: v = 32'd20861;
        5'd16: v = 32'd10430;
        5'd17: v = 32'd5215;
        5'd18: v = 32'd2608;
        5'd19: v = 32'd1304;
        5'd20: v = 32'd652;
        5'd21: v = 32'd326;
        5'd22: v = 32'd163;
        5'd23: v = 32'd81;
        default: v = '0;
      endcase
      return v;
    end
  endfunction

endpackage

[design/magnetometer_calibrated_heading.sv]
// ----------------------------------------------------------------------------
// magnetometer_calibrated_heading: hard-iron calibrated compass heading
// Tracks per-axis min/max, centers and cross-scales the sample, then finds
// atan2 by iterative CORDIC vectoring into a binary angle.
// ----------------------------------------------------------------------------
// One word passes through the CALC, MUL, CORDIC and OUT states from acceptance to
// the result, and the next word is taken once the
// result has been delivered. The two cross products are formed by two
// shift-and-add multipliers side by side that each retire one multiplier bit per cycle, and the
// angle by one shared CORDIC stage that runs once per step. A word with a
// zero axis range skips both, going from MUL straight to OUT, and reports an invalid heading.

module magnetometer_calibrated_heading #(
  parameter int unsigned CORDIC_STEPS = 16,
  parameter int unsigned ANGLE_BITS   = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] mag_x,
  input  logic [15:0] mag_y,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] heading_angle,
  output logic        heading_valid
);

  localparam int unsigned SW = mch_pkg::SAMPLE_W;
  localparam int unsigned DW = mch_pkg::DIFF_W;
  localparam int unsigned RW = mch_pkg::RANGE_W;
  localparam int unsigned PW = mch_pkg::PROD_W;
  localparam int unsigned CW = mch_pkg::CORD_W;
  localparam int unsigned AW = mch_pkg::ACC_W;
  localparam int unsigned NSTEPS =
    (CORDIC_STEPS > mch_pkg::MAX_STEPS) ? mch_pkg::MAX_STEPS : CORDIC_STEPS;
  localparam logic [AW-1:0] ROUND_ADD = AW'(1) << (AW - 1 - ANGLE_BITS);
  localparam int unsigned MCNT_W = $clog2(RW + 1);

  mch_pkg::state_t state, state_next;

  logic signed [SW-1:0] min_x, min_y, max_x, max_y;
  logic signed [SW-1:0] sx, sy;
  logic signed [DW-1:0] dx, dy;
  logic        [RW-1:0] rx, ry;
  logic signed [PW-1:0] px, py;
  logic        [RW-1:0] mplr_x, mplr_y;
  logic signed [PW-1:0] mcand_x, mcand_y;
  logic [MCNT_W-1:0] mcnt;
  logic signed [CW-1:0] cx, cy;
  logic [AW-1:0] acc;
  logic [4:0] step;
  logic       cord_run;
  logic [15:0] angle_out;
  logic        angle_ok;

  // Running extremes, including the current sample.
  logic signed [SW-1:0] nmin_x, nmin_y, nmax_x, nmax_y;
  always_comb begin
    nmin_x = (sx < min_x) ? sx : min_x;
    nmin_y = (sy < min_y) ? sy : min_y;
    nmax_x = (sx > max_x) ? sx : max_x;
    nmax_y = (sy > max_y) ? sy : max_y;
  end

  // Sign-extended 64-bit views of the products, scaled by 2^24.
  logic signed [CW-1:0] px_w, py_w;
  assign px_w = CW'(px) <<< mch_pkg::PRESCALE;
  assign py_w = CW'(py) <<< mch_pkg::PRESCALE;

  // One CORDIC vectoring step.
  logic signed [CW-1:0] xs, ys, cx_step, cy_step;
  logic [AW-1:0] acc_step;
  always_comb begin
    xs = cx >>> step;
    ys = cy >>> step;
    if (!cy[CW-1]) begin
      cx_step  = cx + ys;
      cy_step  = cy - xs;
      acc_step = acc + mch_pkg::atan_turn(step);
    end else begin
      cx_step  = cx - ys;
      cy_step  = cy + xs;
      acc_step = acc - mch_pkg::atan_turn(step);
    end
  end

  logic [AW-1:0] acc_round;
  assign acc_round = acc + ROUND_ADD;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mch_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      mch_pkg::ST_IDLE:   if (in_valid) state_next = mch_pkg::ST_CALC;
      mch_pkg::ST_CALC:   state_next = mch_pkg::ST_MUL;
      mch_pkg::ST_MUL: begin
        if (rx == '0 || ry == '0) begin
          state_next = mch_pkg::ST_OUT;
        end else if (32'(mcnt) == RW) begin
          state_next = mch_pkg::ST_CORDIC;
        end
      end
      mch_pkg::ST_CORDIC: if (32'(step) == NSTEPS) state_next = mch_pkg::ST_OUT;
      mch_pkg::ST_OUT:    if (!out_stall) state_next = mch_pkg::ST_IDLE;
      default:            state_next = mch_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      min_x <= mch_pkg::SAMPLE_MAX;
      min_y <= mch_pkg::SAMPLE_MAX;
      max_x <= mch_pkg::SAMPLE_MIN;
      max_y <= mch_pkg::SAMPLE_MIN;
    end else if (state == mch_pkg::ST_CALC) begin
      min_x <= nmin_x;
      min_y <= nmin_y;
      max_x <= nmax_x;
      max_y <= nmax_y;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      mch_pkg::ST_IDLE: begin
        sx <= mag_x;
        sy <= mag_y;
      end
      mch_pkg::ST_CALC: begin
        dx <= (DW'(sx) <<< 1) - (DW'(nmin_x) + DW'(nmax_x));
        dy <= (DW'(sy) <<< 1) - (DW'(nmin_y) + DW'(nmax_y));
        rx <= RW'(DW'(nmax_x) - DW'(nmin_x));
        ry <= RW'(DW'(nmax_y) - DW'(nmin_y));
        mcnt <= '0;
      end
      mch_pkg::ST_MUL: begin
        if (mcnt == '0) begin
          // Load: X = dx * ry, Y = dy * rx, one multiplier bit per cycle.
          mcand_x <= PW'(dx);
          mcand_y <= PW'(dy);
          mplr_x  <= ry;
          mplr_y  <= rx;
          px      <= '0;
          py      <= '0;
          mcnt    <= mcnt + 1'b1;
        end else begin
          if (mplr_x[0]) px <= px + mcand_x;
          if (mplr_y[0]) py <= py + mcand_y;
          mcand_x <= mcand_x <<< 1;
          mcand_y <= mcand_y <<< 1;
          mplr_x  <= mplr_x >> 1;
          mplr_y  <= mplr_y >> 1;
          mcnt    <= mcnt + 1'b1;
        end
        step <= '0;
        cord_run <= 1'b0;
        angle_ok <= !(rx == '0 || ry == '0);
        angle_out <= '0;
      end
      mch_pkg::ST_CORDIC: begin
        // The first CORDIC cycle loads the vector; the steps then run from 0, unless the vector is zero.
        if (!cord_run && px == '0 && py == '0) begin
          step     <= 5'(NSTEPS);
          acc      <= '0;
          cx       <= '0;
          cy       <= '0;
          cord_run <= 1'b1;
        end else if (!cord_run && !px[PW-1]) begin
          cx       <= px_w;
          cy       <= py_w;
          acc      <= '0;
          cord_run <= 1'b1;
        end else if (!cord_run) begin
          cx       <= -px_w;
          cy       <= -py_w;
          acc      <= mch_pkg::HALF_TURN;
          cord_run <= 1'b1;
        end else if (32'(step) == NSTEPS) begin
          angle_out <= 16'((acc_round >> (AW - ANGLE_BITS)) &
                           ((AW'(1) << ANGLE_BITS) - AW'(1)));
        end else begin
          cx   <= cx_step;
          cy   <= cy_step;
          acc  <= acc_step;
          step <= step + 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign in_stall      = (state != mch_pkg::ST_IDLE);
  assign out_valid     = (state == mch_pkg::ST_OUT);
  assign heading_angle = angle_out;
  assign heading_valid = angle_ok;

  ast_extremes_ordered: assert property (@(posedge clk) disable iff (rst)
    (state == mch_pkg::ST_OUT && angle_ok) |-> (min_x < max_x && min_y < max_y))
    else $error("valid heading with an empty axis range");

  ast_one_result: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall) |=> !out_valid)
    else $error("result delivered twice");

  ast_accept_idle: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> (state == mch_pkg::ST_CALC))
    else $error("accepted word did not start work");

endmodule

[bench/magnetometer_calibrated_heading_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// magnetometer_calibrated_heading_tb: self-checking bench of the heading block
// Drives raw x/y samples, predicts the calibrated heading with its own min/max
// tracker and CORDIC, and compares every result word in order.
// ----------------------------------------------------------------------------
module magnetometer_calibrated_heading_tb;

  localparam int unsigned STEPS      = 16;
  localparam int unsigned ANG_BITS   = 16;
  localparam int unsigned CYCLE_CAP  = 1_000_000;

  typedef struct packed {
    logic [15:0] mag_x;
    logic [15:0] mag_y;
  } sample_t;

  typedef struct packed {
    logic [15:0] angle;
    logic        valid;
  } heading_t;

  typedef enum int {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [15:0] mag_x;
  logic [15:0] mag_y;
  logic        out_valid;
  logic        out_stall;
  logic [15:0] heading_angle;
  logic        heading_valid;
  logic        in_accepted;

  sample_t    pending_samples[$];
  heading_t   expected_headings[$];
  idle_mode_t idle_mode;
  int         hold_off_cycles;
  int         mismatch_count;
  int         result_count;
  int         valid_result_count;
  int         cycle_count;

  // Predictor copy of the calibration extremes.
  logic signed [15:0] cal_min_x, cal_min_y, cal_max_x, cal_max_y;

  magnetometer_calibrated_heading #(
    .CORDIC_STEPS(STEPS),
    .ANGLE_BITS  (ANG_BITS)
  ) i_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .mag_x        (mag_x),
    .mag_y        (mag_y),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .heading_angle(heading_angle),
    .heading_valid(heading_valid)
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  function automatic logic signed [63:0] floor_shr(input logic signed [63:0] v,
                                                   input int unsigned s);
    return v >>> s;
  endfunction

  function automatic logic [31:0] cordic_turn(input logic signed [63:0] xi,
                                              input logic signed [63:0] yi);
    logic signed [63:0] x, y, xs, ys;
    logic [31:0] acc;
    acc = '0;
    x = xi;
    y = yi;
    if (x < 0) begin
      x = -x;
      y = -y;
      acc = mch_pkg::HALF_TURN;
    end
    for (int i = 0; i < STEPS; i++) begin
      xs = floor_shr(x, i);
      ys = floor_shr(y, i);
      if (y >= 0) begin
        x = x + ys;
        y = y - xs;
        acc = acc + mch_pkg::atan_turn(i[4:0]);
      end else begin
        x = x - ys;
        y = y + xs;
        acc = acc - mch_pkg::atan_turn(i[4:0]);
      end
    end
    return acc;
  endfunction

  function automatic heading_t predict_heading(input sample_t s);
    logic signed [63:0] sx, sy, rx, ry, cx, cy;
    logic [31:0] acc;
    heading_t h;
    sx = 64'(signed'(s.mag_x));
    sy = 64'(signed'(s.mag_y));
    if (signed'(s.mag_x) < cal_min_x) cal_min_x = s.mag_x;
    if (signed'(s.mag_y) < cal_min_y) cal_min_y = s.mag_y;
    if (signed'(s.mag_x) > cal_max_x) cal_max_x = s.mag_x;
    if (signed'(s.mag_y) > cal_max_y) cal_max_y = s.mag_y;
    rx = 64'(cal_max_x) - 64'(cal_min_x);
    ry = 64'(cal_max_y) - 64'(cal_min_y);
    h = '0;
    if (rx <= 0 || ry <= 0) return h;
    cx = (2 * sx - (64'(cal_min_x) + 64'(cal_max_x))) * ry;
    cy = (2 * sy - (64'(cal_min_y) + 64'(cal_max_y))) * rx;
    h.valid = 1'b1;
    if (cx != 0 || cy != 0) begin
      acc = cordic_turn(cx <<< mch_pkg::PRESCALE, cy <<< mch_pkg::PRESCALE);
      acc = acc + (32'd1 << (31 - ANG_BITS));
      h.angle = 16'(acc >> (32 - ANG_BITS));
    end
    return h;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch at result %0d: %s got %0d expected %0d",
             result_count, what, got, want);
    mismatch_count++;
  endtask

  function automatic bit idle_roll(input bit sender);
    case (idle_mode)
      IDLE_SENDER:   return sender && $urandom_range(99) < 76;
      IDLE_RECEIVER: return !sender && $urandom_range(99) < 76;
      IDLE_BOTH:     return $urandom_range(99) < 13;
      default:       return 1'b0;
    endcase
  endfunction

  // Remember whether the word on the input was taken at the last rising edge.
  always @(posedge clk) begin
    if (rst) in_accepted <= 1'b0;
    else in_accepted <= in_valid && !in_stall;
  end

  // Driver: a word stays put while stalled and is replaced only once taken.
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_accepted) begin
      if (in_accepted) void'(pending_samples.pop_front());
      if (pending_samples.size() > 0 && !idle_roll(1'b1)) begin
        in_valid <= 1'b1;
        mag_x    <= pending_samples[0].mag_x;
        mag_y    <= pending_samples[0].mag_y;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (rst) out_stall <= 1'b0;
    else if (hold_off_cycles > 0) out_stall <= 1'b1;
    else out_stall <= idle_roll(1'b0);
  end

  always @(posedge clk) begin
    if (hold_off_cycles > 0) hold_off_cycles <= hold_off_cycles - 1;
  end

  // Prediction happens at acceptance so state follows the accepted order.
  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall)
      expected_headings.push_back(predict_heading(sample_t'{mag_x, mag_y}));
  end

  always @(posedge clk) begin
    heading_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_headings.size() == 0) begin
        report_mismatch("unexpected word, angle", heading_angle, -1);
      end else begin
        want = expected_headings.pop_front();
        if (heading_valid !== want.valid)
          report_mismatch("heading_valid", heading_valid, want.valid);
        if (heading_angle !== want.angle)
          report_mismatch("heading_angle", heading_angle, want.angle);
        if (want.valid) valid_result_count++;
      end
      result_count++;
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_CAP) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("status: fail");
      $finish;
    end
  end

  task automatic add_sample(input logic [15:0] x, input logic [15:0] y);
    pending_samples.push_back(sample_t'{x, y});
  endtask

  task automatic drain();
    while (pending_samples.size() != 0 || in_valid || expected_headings.size() != 0)
      @(posedge clk);
  endtask

  function automatic logic [15:0] near(input int c, input int r);
    return 16'(c + $signed($urandom_range(2 * r)) - r);
  endfunction

  initial begin
    int cx, cy, rad;
    rst = 1'b1;
    in_valid = 1'b0;
    out_stall = 1'b0;
    mag_x = '0;
    mag_y = '0;
    idle_mode = IDLE_NONE;
    hold_off_cycles = 0;
    mismatch_count = 0;
    result_count = 0;
    valid_result_count = 0;
    cycle_count = 0;
    cal_min_x = mch_pkg::SAMPLE_MAX;
    cal_min_y = mch_pkg::SAMPLE_MAX;
    cal_max_x = mch_pkg::SAMPLE_MIN;
    cal_max_y = mch_pkg::SAMPLE_MIN;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: first word has no range, then one axis still flat, extremes,
    // a sample at the exact center, negative x, and axis-aligned headings.
    add_sample(16'h0000, 16'h0000);
    add_sample(16'h0000, 16'h0000);
    add_sample(16'h0064, 16'h0000);
    add_sample(16'h0032, 16'h0000);
    add_sample(16'h8000, 16'h7FFF);
    add_sample(16'h7FFF, 16'h8000);
    add_sample(16'hFFFF, 16'hFFFF);
    add_sample(16'h7FFF, 16'hFFFF);
    add_sample(16'h8000, 16'hFFFF);
    add_sample(16'hFFFF, 16'h7FFF);
    add_sample(16'hFFFF, 16'h8000);
    add_sample(16'h7FFF, 16'h7FFF);
    add_sample(16'h8000, 16'h8000);
    add_sample(16'h7FFF, 16'h8000);
    add_sample(16'h8000, 16'h7FFF);
    add_sample(16'hAAAA, 16'h5555);
    add_sample(16'h5555, 16'hAAAA);
    drain();

    // Random phases: all phases but phase 3 draw readings around a random center with a
    // hard-iron offset, one in ten on average full-range noise; phase 3 is all noise.
    for (int phase = 0; phase < 8; phase++) begin
      idle_mode = idle_mode_t'(phase % 4);
      if (phase == 5) hold_off_cycles = 3000;
      cx = $signed($urandom_range(16000)) - 8000;
      cy = $signed($urandom_range(16000)) - 8000;
      rad = 1 + $urandom_range(20000);
      for (int n = 0; n < 216; n++) begin
        if (phase == 3 || $urandom_range(9) == 0)
          add_sample(16'($urandom), 16'($urandom));
        else
          add_sample(near(cx, rad), near(cy, rad));
      end
      drain();
    end

    repeat (200) @(posedge clk);
    $display("covered %0d result words, %0d with a valid heading, over idle and stall mixes",
             result_count, valid_result_count);
    if (mismatch_count == 0 && expected_headings.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
